/* rtl/core/iscl_pkg.sv */
// Shared types and constants for the IFF sequence chunk locator.
// No dependencies; used by every module under rtl/core.
`default_nettype none

package iscl_pkg;

  localparam int LEN_W = 32;
  localparam int END_W = LEN_W + 2;

  localparam logic [31:0] TAG_FORM = 32'h464F524D;
  localparam logic [31:0] TAG_CAT  = 32'h43415420;
  localparam logic [31:0] TAG_XMID = 32'h584D4944;

  localparam logic [3:0] HDR_TAG_LAST = 4'd3;
  localparam logic [3:0] HDR_LEN_FIRST = 4'd4;
  localparam logic [3:0] HDR_TYPE_FIRST = 4'd8;
  localparam logic [3:0] HDR_LAST = 4'd11;

  localparam logic [LEN_W-1:0] MIN_LEN = 32'd4;
  localparam logic [LEN_W:0] LEN_BIAS = 33'd8;
  localparam int HDR_BYTES = 12;

  typedef enum logic [2:0] {
    PH_OUTER_HDR,
    PH_OUTER_SKIP,
    PH_INNER_HDR,
    PH_INNER_SKIP,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_FOUND,
    ST_BAD_TAG,
    ST_ABSENT,
    ST_ENDED
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] chunk_offset;
  } result_t;

  function automatic logic [7:0] upper_byte(input logic [7:0] b);
    if (b >= 8'h61 && b <= 8'h7A) begin
      return b - 8'h20;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/iscl_in_reg.sv */
// Input register stage of the IFF sequence chunk locator.
// Depends on iscl_pkg for the beat type.
`default_nettype none

module iscl_in_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire iscl_pkg::in_beat_t s_beat,
  input  wire logic               take,
  output logic                    valid,
  output iscl_pkg::in_beat_t      beat
);

  assign s_tready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      beat <= s_beat;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/iscl_parser.sv */
// Chunk header parser: keeps scan state, decides one byte per cycle on step.
// Depends on iscl_pkg for phases, status codes, tags and types.
`default_nettype none

module iscl_parser #(
  parameter int OFFSET_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [7:0]         cfg_wr_data,
  input  wire logic               step,
  input  wire iscl_pkg::in_beat_t beat,
  output logic                    res_valid,
  output iscl_pkg::result_t       result
);

  localparam int OB = OFFSET_BITS;
  localparam int EW = iscl_pkg::END_W;

  logic [7:0] sequence_index;

  iscl_pkg::phase_t phase, phase_next;
  logic [OB-1:0]    byte_position, byte_position_next;
  logic [3:0]       header_byte_index, header_byte_index_next;
  logic             outer_is_cat, outer_is_cat_next;
  logic [31:0]      tag_shift, tag_shift_next;
  logic [31:0]      chunk_length, chunk_length_next;
  logic [OB-1:0]    chunk_start, chunk_start_next;
  logic [EW-1:0]    next_chunk_start, next_chunk_start_next;
  logic [EW-1:0]    container_end, container_end_next;
  logic [7:0]       sequences_left, sequences_left_next;

  logic              fin;
  iscl_pkg::status_t fin_status;
  logic [31:0]       fin_offset;

  always_comb begin : decode
    logic            inner;
    logic [3:0]      idx;
    logic [32:0]     total;
    logic [EW-1:0]   end_pos;
    phase_next             = phase;
    byte_position_next     = byte_position;
    header_byte_index_next = header_byte_index;
    outer_is_cat_next      = outer_is_cat;
    tag_shift_next         = tag_shift;
    chunk_length_next      = chunk_length;
    chunk_start_next       = chunk_start;
    next_chunk_start_next  = next_chunk_start;
    container_end_next     = container_end;
    sequences_left_next    = sequences_left;
    fin        = 1'b0;
    fin_status = iscl_pkg::ST_FOUND;
    fin_offset = 32'd0;
    inner      = 1'b0;
    idx        = header_byte_index;
    total      = '0;
    end_pos    = '0;

    if (beat.first_byte) begin
      phase_next             = iscl_pkg::PH_OUTER_HDR;
      byte_position_next     = '0;
      header_byte_index_next = '0;
      outer_is_cat_next      = 1'b0;
      tag_shift_next         = '0;
      chunk_length_next      = '0;
      chunk_start_next       = '0;
      next_chunk_start_next  = '0;
      container_end_next     = '0;
      sequences_left_next    = '0;
    end

    if (phase_next != iscl_pkg::PH_DONE) begin
      if ((phase_next == iscl_pkg::PH_OUTER_SKIP || phase_next == iscl_pkg::PH_INNER_SKIP) &&
          EW'(byte_position_next) == next_chunk_start_next) begin
        phase_next = (phase_next == iscl_pkg::PH_OUTER_SKIP) ? iscl_pkg::PH_OUTER_HDR
                                                              : iscl_pkg::PH_INNER_HDR;
        header_byte_index_next = '0;
      end

      if (phase_next == iscl_pkg::PH_OUTER_HDR || phase_next == iscl_pkg::PH_INNER_HDR) begin
        inner = (phase_next == iscl_pkg::PH_INNER_HDR);
        idx   = header_byte_index_next;
        if (idx == '0) begin
          chunk_start_next = byte_position_next;
        end
        if (idx >= iscl_pkg::HDR_LEN_FIRST && idx < iscl_pkg::HDR_TYPE_FIRST) begin
          chunk_length_next = {chunk_length_next[23:0], beat.data_byte};
        end else begin
          tag_shift_next = {tag_shift_next[23:0], iscl_pkg::upper_byte(beat.data_byte)};
        end
        header_byte_index_next = idx + 4'd1;

        if (!inner && idx == iscl_pkg::HDR_TAG_LAST) begin
          priority if (tag_shift_next == iscl_pkg::TAG_CAT) begin
            outer_is_cat_next = 1'b1;
          end else if (tag_shift_next == iscl_pkg::TAG_FORM) begin
            outer_is_cat_next = 1'b0;
          end else begin
            fin        = 1'b1;
            fin_status = iscl_pkg::ST_BAD_TAG;
          end
        end

        if (!fin && idx == iscl_pkg::HDR_LAST) begin
          header_byte_index_next = '0;
          total   = iscl_pkg::LEN_BIAS + {1'b0, chunk_length_next};
          end_pos = EW'(chunk_start_next) + EW'(total);
          if (chunk_length_next < iscl_pkg::MIN_LEN) begin
            fin        = 1'b1;
            fin_status = iscl_pkg::ST_ENDED;
          end else if (!inner) begin
            if (tag_shift_next != iscl_pkg::TAG_XMID) begin
              if (|end_pos[EW-1:OB]) begin
                fin        = 1'b1;
                fin_status = iscl_pkg::ST_ENDED;
              end else begin
                next_chunk_start_next = end_pos;
                phase_next            = iscl_pkg::PH_OUTER_SKIP;
              end
            end else if (!outer_is_cat_next) begin
              fin = 1'b1;
              if (sequence_index == 8'd0) begin
                fin_status = iscl_pkg::ST_FOUND;
                fin_offset = 32'(chunk_start_next);
              end else begin
                fin_status = iscl_pkg::ST_ABSENT;
              end
            end else begin
              container_end_next    = end_pos;
              sequences_left_next   = sequence_index;
              next_chunk_start_next = EW'(chunk_start_next) + EW'(iscl_pkg::HDR_BYTES);
              if (next_chunk_start_next >= end_pos) begin
                fin        = 1'b1;
                fin_status = iscl_pkg::ST_ABSENT;
              end else begin
                phase_next = iscl_pkg::PH_INNER_SKIP;
              end
            end
          end else begin
            if (tag_shift_next == iscl_pkg::TAG_XMID && sequences_left_next == 8'd0) begin
              fin        = 1'b1;
              fin_status = iscl_pkg::ST_FOUND;
              fin_offset = 32'(chunk_start_next);
            end else begin
              if (tag_shift_next == iscl_pkg::TAG_XMID) begin
                sequences_left_next = sequences_left_next - 8'd1;
              end
              next_chunk_start_next = end_pos;
              if (end_pos >= container_end_next) begin
                fin        = 1'b1;
                fin_status = iscl_pkg::ST_ABSENT;
              end else if (|end_pos[EW-1:OB]) begin
                fin        = 1'b1;
                fin_status = iscl_pkg::ST_ENDED;
              end else begin
                phase_next = iscl_pkg::PH_INNER_SKIP;
              end
            end
          end
        end
      end

      byte_position_next = byte_position_next + OB'(1);
      if (!fin && beat.last_byte) begin
        fin        = 1'b1;
        fin_status = iscl_pkg::ST_ENDED;
      end
      if (fin) begin
        phase_next = iscl_pkg::PH_DONE;
      end
    end
  end

  always_comb begin
    res_valid           = step && fin;
    result.status       = fin_status;
    result.chunk_offset = fin_offset;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_index    <= 8'd0;
      phase             <= iscl_pkg::PH_OUTER_HDR;
      byte_position     <= '0;
      header_byte_index <= '0;
      outer_is_cat      <= 1'b0;
      tag_shift         <= '0;
      chunk_length      <= '0;
      chunk_start       <= '0;
      next_chunk_start  <= '0;
      container_end     <= '0;
      sequences_left    <= '0;
    end else begin
      if (cfg_wr_en) begin
        sequence_index <= cfg_wr_data;
      end
      if (step) begin
        phase             <= phase_next;
        byte_position     <= byte_position_next;
        header_byte_index <= header_byte_index_next;
        outer_is_cat      <= outer_is_cat_next;
        tag_shift         <= tag_shift_next;
        chunk_length      <= chunk_length_next;
        chunk_start       <= chunk_start_next;
        next_chunk_start  <= next_chunk_start_next;
        container_end     <= container_end_next;
        sequences_left    <= sequences_left_next;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/iscl_out_reg.sv */
// Result register of the IFF sequence chunk locator.
// Depends on iscl_pkg for the result type.
`default_nettype none

module iscl_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              res_valid,
  input  wire iscl_pkg::result_t res,
  output logic                   ready,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output iscl_pkg::result_t      m_res
);

  assign ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && res_valid) begin
      m_res <= res;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/iff_sequence_chunk_locator.sv */
// IFF sequence chunk locator: scans an IFF image one byte per beat and reports
// where the requested XMID sequence header starts.
// Slave stream: one image byte per beat; tuser marks offset zero of a new image,
// tlast marks the final byte. Each image gives at most one result beat (exactly one
// if it ends with tlast) on the master stream: a status and the chunk header offset
// (zero unless found). Config: cfg_wr_en/cfg_wr_data write the zero-based sequence
// number; write it only while no image is in flight.
// Throughput: one byte per cycle while the result register is not stalled; the parser
// updates its state once per accepted byte.
// Result path: the deciding byte goes from the input register through the combinational
// parser into the result register, which drives m_tvalid.
// Stall: while the result register holds an untaken beat, the input register
// still takes one more byte; after that s_tready drops until m_tready.
// Reset: rst clears both stages and the scan state; the first byte after reset
// counts as offset zero even without tuser. No clearing pass is needed.
// Depends on iscl_pkg, iscl_in_reg, iscl_parser, iscl_out_reg.
`default_nettype none

module iff_sequence_chunk_locator #(
  parameter int OFFSET_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // first_byte
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [1:0] status, [33:2] chunk_offset, [39:34] zero
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data
);

  iscl_pkg::in_beat_t s_beat, beat;
  iscl_pkg::result_t  res, m_res;
  logic               in_valid, take, out_ready, res_valid;

  assign s_beat.data_byte  = s_tdata;
  assign s_beat.first_byte = s_tuser;
  assign s_beat.last_byte  = s_tlast;

  assign take = in_valid && out_ready;

  iscl_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_beat   (s_beat),
    .take     (take),
    .valid    (in_valid),
    .beat     (beat)
  );

  iscl_parser #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (take),
    .beat        (beat),
    .res_valid   (res_valid),
    .result      (res)
  );

  iscl_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .ready     (out_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_res     (m_res)
  );

  assign m_tdata = {6'b0, m_res.chunk_offset, m_res.status};

endmodule

`default_nettype wire

/* test/chunk_locator_checker.sv */
// Checker for iff_sequence_chunk_locator: predicts the result of each image from the
// accepted input beats and compares every output beat field by field.
// Depends on iscl_pkg for the tag constants, phase and status enums and the result struct.
`timescale 1ns / 1ps

module chunk_locator_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [7:0]  s_tdata,
  input  wire logic        s_tuser,
  input  wire logic        s_tlast,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [39:0] m_tdata,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  output int               failures,
  output int               pending,
  output int               results_seen,
  output int               found_seen
);

  localparam logic [63:0] OFFSET_MAX = 64'hFFFF_FFFF;

  iscl_pkg::result_t answer_q[$];
  iscl_pkg::result_t want;
  iscl_pkg::phase_t  ph;
  logic [63:0] pos;
  logic [63:0] next_start;
  logic [63:0] hdr_start;
  logic [63:0] cat_end;
  logic [3:0]  hidx;
  logic        in_cat;
  logic [31:0] tag;
  logic [31:0] len;
  logic [7:0]  seq_index;
  logic [7:0]  seq_left;
  logic        decided;

  function automatic logic [7:0] fold_upper(input logic [7:0] b);
    return (b >= "a" && b <= "z") ? {b[7:6], 1'b0, b[4:0]} : b;
  endfunction

  task automatic restart_scan();
    ph         = iscl_pkg::PH_OUTER_HDR;
    pos        = '0;
    hidx       = '0;
    in_cat     = 1'b0;
    tag        = '0;
    len        = '0;
    hdr_start  = '0;
    next_start = '0;
    cat_end    = '0;
    seq_left   = '0;
  endtask

  task automatic conclude(input iscl_pkg::status_t s, input logic [31:0] off);
    iscl_pkg::result_t r;
    r.status       = s;
    r.chunk_offset = off;
    answer_q.push_back(r);
    ph      = iscl_pkg::PH_DONE;
    decided = 1'b1;
  endtask

  task automatic close_header(input logic inner);
    logic [63:0] total;
    logic [63:0] stop;
    total = 64'd8 + {32'd0, len};
    stop  = hdr_start + total;
    if (total < 64'd12) begin
      conclude(iscl_pkg::ST_ENDED, '0);
    end else if (!inner) begin
      if (tag != iscl_pkg::TAG_XMID) begin
        if (stop > OFFSET_MAX) begin
          conclude(iscl_pkg::ST_ENDED, '0);
        end else begin
          next_start = stop;
          ph = iscl_pkg::PH_OUTER_SKIP;
        end
      end else if (!in_cat) begin
        if (seq_index == 8'd0) begin
          conclude(iscl_pkg::ST_FOUND, hdr_start[31:0]);
        end else begin
          conclude(iscl_pkg::ST_ABSENT, '0);
        end
      end else begin
        cat_end    = stop;
        seq_left   = seq_index;
        next_start = hdr_start + 64'd12;
        if (next_start >= cat_end) begin
          conclude(iscl_pkg::ST_ABSENT, '0);
        end else begin
          ph = iscl_pkg::PH_INNER_SKIP;
        end
      end
    end else if (tag == iscl_pkg::TAG_XMID && seq_left == 8'd0) begin
      conclude(iscl_pkg::ST_FOUND, hdr_start[31:0]);
    end else begin
      if (tag == iscl_pkg::TAG_XMID) begin
        seq_left--;
      end
      next_start = stop;
      if (next_start >= cat_end) begin
        conclude(iscl_pkg::ST_ABSENT, '0);
      end else if (next_start > OFFSET_MAX) begin
        conclude(iscl_pkg::ST_ENDED, '0);
      end else begin
        ph = iscl_pkg::PH_INNER_SKIP;
      end
    end
  endtask

  task automatic track_byte(input logic [7:0] d, input logic f, input logic l);
    logic       inner;
    logic [3:0] idx;
    decided = 1'b0;
    if (f) begin
      restart_scan();
    end
    if (ph != iscl_pkg::PH_DONE) begin
      if ((ph == iscl_pkg::PH_OUTER_SKIP || ph == iscl_pkg::PH_INNER_SKIP) &&
          pos == next_start) begin
        ph   = (ph == iscl_pkg::PH_OUTER_SKIP) ? iscl_pkg::PH_OUTER_HDR
                                               : iscl_pkg::PH_INNER_HDR;
        hidx = '0;
      end
      if (ph == iscl_pkg::PH_OUTER_HDR || ph == iscl_pkg::PH_INNER_HDR) begin
        inner = (ph == iscl_pkg::PH_INNER_HDR);
        idx   = hidx;
        if (idx == 4'd0) begin
          hdr_start = pos;
        end
        if (idx >= iscl_pkg::HDR_LEN_FIRST && idx < iscl_pkg::HDR_TYPE_FIRST) begin
          len = {len[23:0], d};
        end else begin
          tag = {tag[23:0], fold_upper(d)};
        end
        hidx = idx + 4'd1;
        if (!inner && idx == iscl_pkg::HDR_TAG_LAST) begin
          if (tag == iscl_pkg::TAG_CAT) begin
            in_cat = 1'b1;
          end else if (tag == iscl_pkg::TAG_FORM) begin
            in_cat = 1'b0;
          end else begin
            conclude(iscl_pkg::ST_BAD_TAG, '0);
          end
        end
        if (!decided && idx == iscl_pkg::HDR_LAST) begin
          hidx = '0;
          close_header(inner);
        end
      end
      pos++;
      if (!decided && l && ph != iscl_pkg::PH_DONE) begin
        conclude(iscl_pkg::ST_ENDED, '0);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      seq_index = '0;
      restart_scan();
      answer_q.delete();
    end else begin
      if (cfg_wr_en) begin
        seq_index = cfg_wr_data;
      end
      if (s_tvalid && s_tready) begin
        track_byte(s_tdata, s_tuser, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (answer_q.size() == 0) begin
          $error("result beat with nothing expected: status %0d, chunk_offset 0x%08h",
                 m_tdata[1:0], m_tdata[33:2]);
          failures++;
        end else begin
          want = answer_q.pop_front();
          if (m_tdata[1:0] == iscl_pkg::ST_FOUND) begin
            found_seen++;
          end
          if (m_tdata[1:0] != want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
            failures++;
          end
          if (m_tdata[33:2] != want.chunk_offset) begin
            $error("chunk_offset: expected 0x%08h, got 0x%08h",
                   want.chunk_offset, m_tdata[33:2]);
            failures++;
          end
        end
      end
    end
    pending = answer_q.size();
  end

endmodule

/* test/iff_sequence_chunk_locator_test.sv */
// Testbench top for iff_sequence_chunk_locator: builds directed and random IFF images,
// streams them with bursty input and stalling output, and reports the verdict.
// Depends on iscl_pkg, the locator RTL and chunk_locator_checker.
`timescale 1ns / 1ps

module iff_sequence_chunk_locator_test;

  localparam int STIM_BYTES  = 1150;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 6;

  localparam logic [31:0] TAG_LIST = "LIST";
  localparam logic [31:0] TAG_RIFF = "RIFF";
  localparam logic [31:0] TAG_NEAR = "FORX";
  localparam logic [31:0] TYP_INFO = "INFO";
  localparam logic [31:0] TYP_XDIR = "XDIR";

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  int failures;
  int pending;
  int results_seen;
  int found_seen;

  logic [7:0] img[$];
  int         bytes_sent;
  int         images;
  int         cfg_writes;
  int         burst_left;
  int         cycles;
  rx_mode_t   rx_mode;
  int         rx_left;

  iff_sequence_chunk_locator #(
    .OFFSET_BITS(32)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  chunk_locator_checker locator_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .failures    (failures),
    .pending     (pending),
    .results_seen(results_seen),
    .found_seen  (found_seen)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
      $display("FAIL");
      $finish;
    end
  end

  // output side stalls on its own schedule of open, coin-flip and sparse stretches
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(10, 60);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN: begin
        m_tready <= 1'b1;
      end
      RX_COIN: begin
        m_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        m_tready <= ($urandom_range(0, 9) == 0);
      end
    endcase
  end

  task automatic put_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) begin
      img.push_back(w[8*i +: 8]);
    end
  endtask

  // tags go out in random letter case
  task automatic put_tag(input logic [31:0] t);
    logic [7:0] c;
    for (int i = 3; i >= 0; i--) begin
      c = t[8*i +: 8];
      if (c >= "A" && c <= "Z" && $urandom_range(0, 1)) begin
        c = c + 8'h20;
      end
      img.push_back(c);
    end
  endtask

  task automatic put_noise(input int n);
    repeat (n) img.push_back(8'($urandom()));
  endtask

  task automatic put_chunk(input logic [31:0] t, input logic [31:0] typ, input int payload);
    put_tag(t);
    put_word(32'(4 + payload));
    put_tag(typ);
    put_noise(payload);
  endtask

  function automatic logic [31:0] pick_outer_tag();
    return $urandom_range(0, 1) ? iscl_pkg::TAG_FORM : iscl_pkg::TAG_CAT;
  endfunction

  function automatic logic [31:0] pick_inner_tag();
    case ($urandom_range(0, 3))
      0: return iscl_pkg::TAG_FORM;
      1: return iscl_pkg::TAG_CAT;
      2: return TAG_LIST;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_other_type();
    case ($urandom_range(0, 2))
      0: return TYP_INFO;
      1: return TYP_XDIR;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_type();
    return ($urandom_range(0, 9) < 6) ? iscl_pkg::TAG_XMID : pick_other_type();
  endfunction

  task automatic build_image();
    int          kind;
    int          start;
    logic [31:0] blen;
    kind = $urandom_range(0, 99);
    if (kind < 80 && $urandom_range(0, 3) == 0) begin
      put_chunk(pick_outer_tag(), pick_other_type(), $urandom_range(0, 6));
    end
    if (kind < 40) begin
      start = img.size();
      put_tag(iscl_pkg::TAG_CAT);
      put_word('0);
      put_tag(iscl_pkg::TAG_XMID);
      repeat ($urandom_range(0, 5)) begin
        put_chunk(pick_inner_tag(), pick_type(), $urandom_range(0, 5));
      end
      blen = img.size() - start - 8;
      if ($urandom_range(0, 7) == 0) begin
        blen = blen - $urandom_range(0, blen);
      end
      img[start+4] = blen[31:24];
      img[start+5] = blen[23:16];
      img[start+6] = blen[15:8];
      img[start+7] = blen[7:0];
    end else if (kind < 65) begin
      put_chunk(iscl_pkg::TAG_FORM, pick_type(), $urandom_range(0, 6));
    end else if (kind < 75) begin
      case ($urandom_range(0, 2))
        0: put_tag(TAG_RIFF);
        1: put_tag(TAG_NEAR);
        default: put_word($urandom());
      endcase
      put_noise($urandom_range(0, 8));
    end else if (kind < 85) begin
      if ($urandom_range(0, 1)) begin
        put_tag(iscl_pkg::TAG_CAT);
        put_word(32'd24);
        put_tag(iscl_pkg::TAG_XMID);
        put_tag(pick_inner_tag());
      end else begin
        put_tag(pick_outer_tag());
      end
      put_word($urandom_range(0, 3));
      put_tag(pick_type());
    end else if (kind < 90) begin
      put_tag(pick_outer_tag());
      put_word($urandom());
      put_tag(pick_type());
      put_noise($urandom_range(0, 20));
    end else begin
      put_noise($urandom_range(1, 30));
    end
    put_noise($urandom_range(0, 4));
    if ($urandom_range(0, 15) == 0) begin
      img[$urandom_range(0, img.size() - 1)] = 8'($urandom());
    end
    if ($urandom_range(0, 9) == 0) begin
      img = img[0:$urandom_range(0, img.size() - 1)];
    end
  endtask

  // one beat, inside a burst; a fresh burst begins after a random gap
  task automatic push_byte(input logic [7:0] d, input logic f, input logic l);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 250)
                                                : $urandom_range(1, 16);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= f;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_image(input logic mark_first, input logic mark_last);
    for (int i = 0; i < img.size(); i++) begin
      push_byte(img[i], mark_first && i == 0, mark_last && i == img.size() - 1);
    end
    img.delete();
    images++;
  endtask

  // block idle: nothing outstanding and the pipeline drained
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_index(input logic [7:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [7:0] pick_index();
    int r;
    r = $urandom_range(0, 7);
    if (cfg_writes == 0) begin
      return 8'd255;
    end else if (cfg_writes == 1 || r < 3) begin
      return 8'd0;
    end else if (r < 6) begin
      return 8'($urandom_range(1, 3));
    end
    return 8'($urandom());
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // bad outer tag, with no first marker right after reset
    put_word(TAG_RIFF);
    send_image(1'b0, 1'b0);
    // first and last marker on one beat
    img.push_back(8'h46);
    send_image(1'b1, 1'b1);
    // stated length below the header size
    put_tag(iscl_pkg::TAG_FORM);
    put_word(32'd3);
    put_tag(iscl_pkg::TAG_XMID);
    send_image(1'b1, 1'b1);
    // skipped chunk whose end is past the last reachable offset
    put_tag(iscl_pkg::TAG_FORM);
    put_word(32'hFFFF_FFF8);
    put_word(TYP_INFO);
    send_image(1'b1, 1'b1);

    while (bytes_sent < STIM_BYTES) begin
      if (cfg_writes < 2 || $urandom_range(0, 5) == 0) begin
        write_index(pick_index());
      end
      build_image();
      send_image(1'b1, $urandom_range(0, 9) != 0);
    end

    settle();
    $display("Sent %0d images in %0d bytes with %0d sequence index writes.",
             images, bytes_sent, cfg_writes);
    $display("Checked %0d results, %0d of them located sequences.", results_seen, found_seen);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/iscl_pkg.sv
rtl/core/iscl_in_reg.sv
rtl/core/iscl_parser.sv
rtl/core/iscl_out_reg.sv
rtl/core/iff_sequence_chunk_locator.sv
test/chunk_locator_checker.sv
test/iff_sequence_chunk_locator_test.sv
